@@ rtl/hsvbb_pkg.sv @@
// Package with types, constants and reciprocal tables for the HSV bounding box unit.
`default_nettype none
package hsvbb_pkg;
    localparam int COORD_W = 11;
    localparam int SIZE_W = 12;
    localparam int DEF_MAX_WIDTH = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int HUE_RANGE = 179;
    localparam int FIX_SHIFT = 12;
    localparam int CFG_IDX_W = 3;
    localparam int SAT_REC_W = 20;
    localparam int HUE_REC_W = 18;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_LOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_LOW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VAL_LOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VAL_HIGH = 3'd6;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic last_pixel;
    } t_pixel;

    typedef struct packed {
        logic found;
        logic [COORD_W-1:0] box_x;
        logic [COORD_W-1:0] box_y;
        logic [SIZE_W-1:0] box_width;
        logic [SIZE_W-1:0] box_height;
    } t_box;

    // Classified pixel passed from the front to the back.
    typedef struct packed {
        logic hit;
        logic enable;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic last_pixel;
    } t_event;

    typedef struct packed {
        logic enable;
        logic [7:0] hue_low;
        logic [7:0] sat_low;
        logic [7:0] val_low;
        logic [7:0] hue_high;
        logic [7:0] sat_high;
        logic [7:0] val_high;
    } t_cfg;

    // Integer quotient by shift and subtract, used only while building the tables.
    function automatic int cdiv(input longint num, input longint den);
        longint q;
        longint rem;
        q = 0;
        rem = num;
        for (int k = 21; k >= 0; k--) begin
            if ((den << k) <= rem) begin
                rem = rem - (den << k);
                q = q + (longint'(1) << k);
            end
        end
        return int'(q);
    endfunction

    // Entry v holds round(255*4096/v); entry 0 is zero.
    function automatic logic [256*SAT_REC_W-1:0] build_sat_tab();
        logic [256*SAT_REC_W-1:0] t;
        t = '0;
        for (int v = 1; v < 256; v++)
            t[v*SAT_REC_W +: SAT_REC_W] =
                SAT_REC_W'(cdiv(2 * (255 << FIX_SHIFT) + v, 2 * v));
        return t;
    endfunction

    // Entry d holds round(180*4096/(6*d)); entry 0 is zero.
    function automatic logic [256*HUE_REC_W-1:0] build_hue_tab();
        logic [256*HUE_REC_W-1:0] t;
        t = '0;
        for (int d = 1; d < 256; d++)
            t[d*HUE_REC_W +: HUE_REC_W] =
                HUE_REC_W'(cdiv(2 * ((HUE_RANGE + 1) << FIX_SHIFT) + 6 * d, 12 * d));
        return t;
    endfunction

    localparam logic [256*SAT_REC_W-1:0] SAT_RECIP_TAB = build_sat_tab();
    localparam logic [256*HUE_REC_W-1:0] HUE_RECIP_TAB = build_hue_tab();
endpackage
`default_nettype wire

@@ rtl/hsv_threshold_bounding_box_unit.sv @@
// Top level of the HSV threshold bounding box unit.
// Throughput: one pixel per cycle when the output is not stalled, set by the two-stage conversion pipeline.
// Result path: once the last pixel is accepted it passes the two conversion stages,
// the queue and the tracker output register; backpressure can delay the result.
// Reset: synchronous active low; registers return to defaults, tracker cleared.
`default_nettype none
module hsv_threshold_bounding_box_unit #(
    parameter int MAX_WIDTH = hsvbb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hsvbb_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire hsvbb_pkg::t_pixel                 i_pixel,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output hsvbb_pkg::t_box                        o_box,
    input  wire logic                              i_cfg_we,
    input  wire logic [hsvbb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [7:0]                        i_cfg_data
);
    hsvbb_pkg::t_cfg r_cfg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable <= 1'b1;
            r_cfg.hue_low <= 8'd0;
            r_cfg.sat_low <= 8'd100;
            r_cfg.val_low <= 8'd100;
            r_cfg.hue_high <= 8'd10;
            r_cfg.sat_high <= 8'd255;
            r_cfg.val_high <= 8'd255;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hsvbb_pkg::REG_ENABLE: r_cfg.enable <= i_cfg_data[0];
                hsvbb_pkg::REG_HUE_LOW: r_cfg.hue_low <= i_cfg_data;
                hsvbb_pkg::REG_SAT_LOW: r_cfg.sat_low <= i_cfg_data;
                hsvbb_pkg::REG_VAL_LOW: r_cfg.val_low <= i_cfg_data;
                hsvbb_pkg::REG_HUE_HIGH: r_cfg.hue_high <= i_cfg_data;
                hsvbb_pkg::REG_SAT_HIGH: r_cfg.sat_high <= i_cfg_data;
                hsvbb_pkg::REG_VAL_HIGH: r_cfg.val_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic f_valid, f_ready, q_valid, q_ready;
    hsvbb_pkg::t_event f_event, q_event;

    hsvbb_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_pixel, .i_cfg(r_cfg),
        .o_valid(f_valid), .i_ready(f_ready), .o_event(f_event)
    );
    hsvbb_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_ready(f_ready), .i_data(f_event),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_event)
    );
    hsvbb_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_ready(q_ready), .i_event(q_event),
        .o_valid, .i_ready, .o_box
    );
endmodule
`default_nettype wire

@@ rtl/hsvbb_front.sv @@
// Front part: RGB to HSV conversion pipeline and threshold classification.
`default_nettype none
module hsvbb_front #(
    parameter int MAX_WIDTH = hsvbb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hsvbb_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire hsvbb_pkg::t_pixel i_pixel,
    input  wire hsvbb_pkg::t_cfg   i_cfg,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output hsvbb_pkg::t_event      o_event
);
    localparam int CW = hsvbb_pkg::COORD_W;
    localparam int SRW = hsvbb_pkg::SAT_REC_W;
    localparam int HRW = hsvbb_pkg::HUE_REC_W;

    // Stage 1: max, min, delta, raw hue and reciprocals.
    logic r_v1, r_v2;
    logic [7:0] r_val1, r_d1;
    logic signed [11:0] r_raw1;
    logic [19:0] r_srec1;
    logic [17:0] r_hrec1;
    logic r_in1;
    logic [CW-1:0] r_col1, r_row1;
    logic r_last1, r_en1;
    // Stage 2: products.
    logic [7:0] r_val2;
    logic [27:0] r_sprod2;
    logic signed [29:0] r_hprod2;
    logic r_dz2, r_vz2, r_in2;
    logic [CW-1:0] r_col2, r_row2;
    logic r_last2, r_en2;
    logic r_dz1;

    logic adv;
    assign adv = !r_v2 || i_ready;
    assign o_ready = adv;

    logic [7:0] mx, mn, dd;
    logic signed [11:0] raw;
    logic in_frame;
    always_comb begin
        mx = i_pixel.red;
        if (i_pixel.green > mx) mx = i_pixel.green;
        if (i_pixel.blue > mx) mx = i_pixel.blue;
        mn = i_pixel.red;
        if (i_pixel.green < mn) mn = i_pixel.green;
        if (i_pixel.blue < mn) mn = i_pixel.blue;
        dd = mx - mn;
        if (mx == i_pixel.red)
            raw = $signed({4'b0, i_pixel.green}) - $signed({4'b0, i_pixel.blue});
        else if (mx == i_pixel.green)
            raw = $signed({4'b0, i_pixel.blue}) - $signed({4'b0, i_pixel.red})
                + $signed({3'b0, dd, 1'b0});
        else
            raw = $signed({4'b0, i_pixel.red}) - $signed({4'b0, i_pixel.green})
                + $signed({2'b0, dd, 2'b0});
        in_frame = (32'(i_pixel.col) < 32'(MAX_WIDTH)) && (32'(i_pixel.row) < 32'(MAX_HEIGHT));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_val1 <= mx;
            r_d1 <= dd;
            r_dz1 <= (dd == 8'd0);
            r_raw1 <= raw;
            // Entry zero of each table is zero, which covers a black or gray pixel.
            r_srec1 <= hsvbb_pkg::SAT_RECIP_TAB[int'(mx) * SRW +: SRW];
            r_hrec1 <= hsvbb_pkg::HUE_RECIP_TAB[int'(dd) * HRW +: HRW];
            r_in1 <= in_frame;
            r_col1 <= i_pixel.col;
            r_row1 <= i_pixel.row;
            r_last1 <= i_pixel.last_pixel;
            r_en1 <= i_cfg.enable;
            r_val2 <= r_val1;
            r_sprod2 <= 28'(r_d1) * 28'(r_srec1);
            r_hprod2 <= 30'(r_raw1) * $signed({12'b0, r_hrec1});
            r_dz2 <= r_dz1;
            r_vz2 <= (r_val1 == 8'd0);
            r_in2 <= r_in1;
            r_col2 <= r_col1;
            r_row2 <= r_row1;
            r_last2 <= r_last1;
            r_en2 <= r_en1;
        end
    end

    logic [8:0] sat;
    logic signed [29:0] hsum;
    logic signed [17:0] hq;
    logic [7:0] hue;
    logic hit;
    always_comb begin
        sat = r_vz2 ? 9'd0 : 9'((r_sprod2 + 28'd2048) >> hsvbb_pkg::FIX_SHIFT);
        hsum = r_hprod2 + 30'sd2048;
        hq = 18'(hsum >>> hsvbb_pkg::FIX_SHIFT);
        if (r_dz2) hue = 8'd0;
        else if (hq < 0) hue = 8'(hq + 18'sd180);
        else hue = 8'(hq);
        hit = r_in2 && r_en2
            && hue >= i_cfg.hue_low && hue <= i_cfg.hue_high
            && sat >= {1'b0, i_cfg.sat_low} && sat <= {1'b0, i_cfg.sat_high}
            && r_val2 >= i_cfg.val_low && r_val2 <= i_cfg.val_high;
    end

    assign o_valid = r_v2;
    always_comb begin
        o_event.hit = hit;
        o_event.enable = i_cfg.enable;
        o_event.col = r_col2;
        o_event.row = r_row2;
        o_event.last_pixel = r_last2;
    end
endmodule
`default_nettype wire

@@ rtl/hsvbb_queue.sv @@
// Two-entry queue between the classifier and the box tracker.
`default_nettype none
module hsvbb_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire hsvbb_pkg::t_event i_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output hsvbb_pkg::t_event      o_data
);
    hsvbb_pkg::t_event r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;
    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;
    assign o_data = r_mem[r_rp];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_data;
    end
`ifndef SYNTHESIS
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue count overflow");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !pop) else $error("pop from empty queue");
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop && r_cnt == 2'd1) |=> r_cnt == 2'd2) else $error("count slip");
`endif
endmodule
`default_nettype wire

@@ rtl/hsvbb_back.sv @@
// Back part: tracks the box of matching pixels and emits one result per frame.
`default_nettype none
module hsvbb_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire hsvbb_pkg::t_event i_event,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output hsvbb_pkg::t_box        o_box
);
    localparam int CW = hsvbb_pkg::COORD_W;
    logic r_any, r_ov;
    logic [CW-1:0] r_minc, r_maxc, r_minr, r_maxr;
    hsvbb_pkg::t_box r_box, n_box;
    logic take;
    logic [CW-1:0] nminc, nmaxc, nminr, nmaxr;
    logic nany;

    assign o_ready = !r_ov || i_ready;
    assign take = i_valid && o_ready;

    always_comb begin
        nany = r_any; nminc = r_minc; nmaxc = r_maxc; nminr = r_minr; nmaxr = r_maxr;
        if (i_event.hit) begin
            nany = 1'b1;
            if (!r_any) begin
                nminc = i_event.col; nmaxc = i_event.col;
                nminr = i_event.row; nmaxr = i_event.row;
            end else begin
                if (i_event.col < r_minc) nminc = i_event.col;
                if (i_event.col > r_maxc) nmaxc = i_event.col;
                if (i_event.row < r_minr) nminr = i_event.row;
                if (i_event.row > r_maxr) nmaxr = i_event.row;
            end
        end
        n_box = '0;
        if (i_event.enable && nany) begin
            n_box.found = 1'b1;
            n_box.box_x = nminc;
            n_box.box_y = nminr;
            n_box.box_width = {1'b0, nmaxc} - {1'b0, nminc} + 12'd1;
            n_box.box_height = {1'b0, nmaxr} - {1'b0, nminr} + 12'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any <= 1'b0;
            r_ov <= 1'b0;
            r_minc <= '0; r_maxc <= '0; r_minr <= '0; r_maxr <= '0;
        end else begin
            if (take && i_event.last_pixel) r_ov <= 1'b1;
            else if (r_ov && i_ready) r_ov <= 1'b0;
            if (take) begin
                if (i_event.last_pixel) begin
                    r_any <= 1'b0;
                    r_minc <= '0; r_maxc <= '0; r_minr <= '0; r_maxr <= '0;
                end else begin
                    r_any <= nany;
                    r_minc <= nminc; r_maxc <= nmaxc; r_minr <= nminr; r_maxr <= nmaxr;
                end
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (take && i_event.last_pixel) r_box <= n_box;
    end
    assign o_valid = r_ov;
    assign o_box = r_box;
`ifndef SYNTHESIS
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_event.last_pixel) |=> !r_any) else $error("tracker not cleared");
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_any |-> (r_minc <= r_maxc && r_minr <= r_maxr)) else $error("box inverted");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |=> (r_ov && $stable(r_box))) else $error("result lost");
`endif
endmodule
`default_nettype wire

@@ sim/tb_hsv_threshold_bounding_box_unit.sv @@
// Testbench for the HSV threshold bounding box unit with a built-in frame predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_hsv_threshold_bounding_box_unit;
    localparam int LIMIT_CYCLES = 400000;
    localparam int CW = hsvbb_pkg::COORD_W;
    localparam int SW = hsvbb_pkg::SIZE_W;
    localparam int IW = hsvbb_pkg::CFG_IDX_W;
    // An index that names no register.
    localparam logic [IW-1:0] REG_UNUSED = '1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    hsvbb_pkg::t_pixel i_pixel = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    hsvbb_pkg::t_box o_box;
    logic i_cfg_we = 1'b0;
    logic [IW-1:0] i_cfg_idx = '0;
    logic [7:0] i_cfg_data = '0;

    hsv_threshold_bounding_box_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_pixel(i_pixel),
        .o_valid(o_valid), .i_ready(i_ready), .o_box(o_box),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor copy of the registers and the tracker.
    hsvbb_pkg::t_cfg cfg_shadow;
    logic trk_hit;
    logic [CW-1:0] trk_min_col, trk_min_row, trk_max_col, trk_max_row;

    hsvbb_pkg::t_pixel pending_pixels[$];
    hsvbb_pkg::t_box expected_boxes[$];
    int mismatches = 0;
    int cycles = 0;
    bit stall_long = 1'b0;

    function automatic void pixel_hsv(input hsvbb_pkg::t_pixel p, output int h, output int s,
                                      output int v);
        int r, g, b, mn, d, raw, recip, x;
        r = p.red; g = p.green; b = p.blue;
        v = r; mn = r;
        if (g > v) v = g;
        if (b > v) v = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = v - mn;
        s = 0; h = 0;
        if (v > 0) s = (d * ((2 * (255 << 12) + v) / (2 * v)) + 2048) >> 12;
        if (v == r) raw = g - b;
        else if (v == g) raw = b - r + 2 * d;
        else raw = r - g + 4 * d;
        if (d > 0) begin
            recip = (2 * (180 << 12) + 6 * d) / (12 * d);
            x = raw * recip + 2048;
            h = (x >= 0) ? (x >>> 12) : -((-x + 4095) >>> 12);
        end
        if (h < 0) h += 180;
    endfunction

    function automatic void track_pixel(input hsvbb_pkg::t_pixel p);
        int h, s, v;
        hsvbb_pkg::t_box bx;
        if (cfg_shadow.enable && p.col < hsvbb_pkg::DEF_MAX_WIDTH
            && p.row < hsvbb_pkg::DEF_MAX_HEIGHT) begin
            pixel_hsv(p, h, s, v);
            if (h >= cfg_shadow.hue_low && h <= cfg_shadow.hue_high &&
                s >= cfg_shadow.sat_low && s <= cfg_shadow.sat_high &&
                v >= cfg_shadow.val_low && v <= cfg_shadow.val_high) begin
                if (!trk_hit) begin
                    trk_min_col = p.col; trk_max_col = p.col;
                    trk_min_row = p.row; trk_max_row = p.row;
                    trk_hit = 1'b1;
                end else begin
                    if (p.col < trk_min_col) trk_min_col = p.col;
                    if (p.col > trk_max_col) trk_max_col = p.col;
                    if (p.row < trk_min_row) trk_min_row = p.row;
                    if (p.row > trk_max_row) trk_max_row = p.row;
                end
            end
        end
        if (p.last_pixel) begin
            bx = '0;
            if (cfg_shadow.enable && trk_hit) begin
                bx.found = 1'b1;
                bx.box_x = trk_min_col;
                bx.box_y = trk_min_row;
                bx.box_width = SW'(trk_max_col - trk_min_col) + 1'b1;
                bx.box_height = SW'(trk_max_row - trk_min_row) + 1'b1;
            end
            expected_boxes.push_back(bx);
            trk_hit = 1'b0;
            trk_min_col = '0; trk_min_row = '0; trk_max_col = '0; trk_max_row = '0;
        end
    endfunction

    // Handshake seen at the rising edge, so the driver knows what was accepted.
    logic o_ready_seen = 1'b0;
    always @(posedge i_clk) o_ready_seen <= i_valid && o_ready && i_rst_n;

    // Driver: one item from the queue at a time, random gap before each.
    int send_gap = 0;
    always @(negedge i_clk) begin
        if (i_valid && o_ready_seen) begin
            track_pixel(i_pixel);
            send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
        end
        if (!i_valid || o_ready_seen) begin
            if (send_gap > 0 || pending_pixels.size() == 0) begin
                if (send_gap > 0) send_gap--;
                i_valid <= 1'b0;
            end else begin
                i_pixel <= pending_pixels.pop_front();
                i_valid <= 1'b1;
            end
        end
    end

    // Monitor and receiver throttle.
    int recv_gap = 0;
    int hold_count = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_boxes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected box %p", o_box);
            end else if (o_box !== expected_boxes[0]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("box mismatch: expected %p, got %p", expected_boxes[0], o_box);
                void'(expected_boxes.pop_front());
            end else begin
                void'(expected_boxes.pop_front());
            end
            recv_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
        end
        if (cycles >= LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (stall_long && hold_count < 300) begin
            hold_count <= hold_count + 1;
            i_ready <= 1'b0;
        end else if (recv_gap > 0 && !(o_valid && i_ready)) begin
            recv_gap <= recv_gap - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= !(o_valid && i_ready) || recv_gap == 0;
        end
    end

    task automatic write_reg(input logic [IW-1:0] idx, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            hsvbb_pkg::REG_ENABLE: cfg_shadow.enable = data[0];
            hsvbb_pkg::REG_HUE_LOW: cfg_shadow.hue_low = data;
            hsvbb_pkg::REG_SAT_LOW: cfg_shadow.sat_low = data;
            hsvbb_pkg::REG_VAL_LOW: cfg_shadow.val_low = data;
            hsvbb_pkg::REG_HUE_HIGH: cfg_shadow.hue_high = data;
            hsvbb_pkg::REG_SAT_HIGH: cfg_shadow.sat_high = data;
            hsvbb_pkg::REG_VAL_HIGH: cfg_shadow.val_high = data;
            default: ;
        endcase
    endtask

    task automatic drain;
        while (pending_pixels.size() != 0 || i_valid || expected_boxes.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    function automatic hsvbb_pkg::t_pixel mk_pixel(input int r, input int g, input int b,
                                                   input int c, input int rw, input bit last);
        hsvbb_pkg::t_pixel p;
        p.red = 8'(r); p.green = 8'(g); p.blue = 8'(b);
        p.col = CW'(c); p.row = CW'(rw); p.last_pixel = last;
        return p;
    endfunction

    function automatic hsvbb_pkg::t_pixel rand_pixel(input bit last, input bit near_red);
        hsvbb_pkg::t_pixel p;
        p.red = 8'($urandom); p.green = 8'($urandom); p.blue = 8'($urandom);
        if (near_red) begin
            p.red = 8'($urandom_range(120, 255));
            p.green = 8'($urandom_range(0, 40));
            p.blue = 8'($urandom_range(0, 40));
        end
        p.col = ($urandom_range(0, 7) == 0) ? CW'($urandom) : CW'($urandom_range(0, 63));
        p.row = ($urandom_range(0, 7) == 0) ? CW'($urandom) : CW'($urandom_range(0, 63));
        p.last_pixel = last;
        return p;
    endfunction

    task automatic random_frames(input int n_pixels);
        int k, frame_len;
        k = 0;
        while (k < n_pixels) begin
            frame_len = $urandom_range(1, 24);
            for (int j = 0; j < frame_len; j++)
                pending_pixels.push_back(rand_pixel(j == frame_len - 1, $urandom_range(0, 1)));
            k += frame_len;
        end
    endtask

    initial begin
        cfg_shadow = '{enable: 1'b1, hue_low: 8'd0, sat_low: 8'd100, val_low: 8'd100,
                       hue_high: 8'd10, sat_high: 8'd255, val_high: 8'd255};
        trk_hit = 1'b0;
        trk_min_col = '0; trk_min_row = '0; trk_max_col = '0; trk_max_row = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames with reset settings: extremes of colors and coordinates.
        pending_pixels.push_back(mk_pixel(255, 0, 0, 0, 0, 0));
        pending_pixels.push_back(mk_pixel(255, 0, 0, 2047, 2047, 0));
        pending_pixels.push_back(mk_pixel(0, 0, 0, 5, 5, 0));
        pending_pixels.push_back(mk_pixel(255, 255, 255, 6, 6, 0));
        pending_pixels.push_back(mk_pixel(255, 0, 255, 7, 7, 0));
        pending_pixels.push_back(mk_pixel(0, 255, 0, 8, 8, 0));
        pending_pixels.push_back(mk_pixel(0, 0, 255, 9, 9, 0));
        pending_pixels.push_back(mk_pixel(254, 0, 255, 10, 10, 0));
        pending_pixels.push_back(mk_pixel(200, 30, 10, 100, 3, 1));
        // A frame with nothing matching.
        pending_pixels.push_back(mk_pixel(0, 255, 255, 1, 1, 1));
        pending_pixels.push_back(mk_pixel(255, 10, 0, 1024, 1024, 1));
        drain();

        // Detection disabled, then enabled again.
        write_reg(hsvbb_pkg::REG_ENABLE, 8'h00);
        pending_pixels.push_back(mk_pixel(255, 0, 0, 3, 3, 0));
        pending_pixels.push_back(mk_pixel(255, 0, 0, 4, 4, 1));
        drain();
        write_reg(hsvbb_pkg::REG_ENABLE, 8'hFF);

        // Wide-open bounds, also with an out-of-range register index.
        write_reg(hsvbb_pkg::REG_HUE_LOW, 8'd0);
        write_reg(hsvbb_pkg::REG_HUE_HIGH, 8'd255);
        write_reg(hsvbb_pkg::REG_SAT_LOW, 8'd0);
        write_reg(hsvbb_pkg::REG_SAT_HIGH, 8'd255);
        write_reg(hsvbb_pkg::REG_VAL_LOW, 8'd0);
        write_reg(hsvbb_pkg::REG_VAL_HIGH, 8'd255);
        write_reg(REG_UNUSED, 8'h5A);
        random_frames(250);
        // Receiver holds off for a long stretch while pixels keep coming.
        stall_long = 1'b1;
        drain();

        // Inverted bounds match nothing.
        write_reg(hsvbb_pkg::REG_HUE_LOW, 8'd179);
        write_reg(hsvbb_pkg::REG_HUE_HIGH, 8'd0);
        random_frames(100);
        drain();

        // Narrow and random bounds, with detection disabled in one phase.
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(hsvbb_pkg::REG_HUE_LOW, 8'($urandom_range(0, 100)));
            write_reg(hsvbb_pkg::REG_HUE_HIGH, 8'($urandom_range(60, 179)));
            write_reg(hsvbb_pkg::REG_SAT_LOW, 8'($urandom_range(0, 150)));
            write_reg(hsvbb_pkg::REG_SAT_HIGH, 8'($urandom_range(120, 255)));
            write_reg(hsvbb_pkg::REG_VAL_LOW, 8'($urandom_range(0, 150)));
            write_reg(hsvbb_pkg::REG_VAL_HIGH, 8'($urandom_range(120, 255)));
            write_reg(hsvbb_pkg::REG_ENABLE, 8'(ph != 3));
            random_frames(110);
            drain();
        end

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
rtl/hsvbb_pkg.sv
rtl/hsvbb_front.sv
rtl/hsvbb_queue.sv
rtl/hsvbb_back.sv
rtl/hsv_threshold_bounding_box_unit.sv
sim/tb_hsv_threshold_bounding_box_unit.sv
